@@ hw/rtl/abamm_pkg.sv @@
// ----------------------------------------------------------------------------
// abamm_pkg
// Shared widths, codes and types of the burst averager with min/max tracking.
// ----------------------------------------------------------------------------
package abamm_pkg;

  localparam int FRAME_W  = 16;
  localparam int CODE_W   = 12;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 20;
  localparam int MODE_W   = 2;
  localparam int SCALED_W = 16;
  localparam int PROD_W   = 2 * CODE_W;
  localparam int STEP_W   = 5;

  // converter full scale in millivolts, temperature sensor offset
  localparam int MV_FULL        = 3300;
  localparam int TEMP_OFFSET_MV = 500;

  localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

  // configuration register indexes
  localparam logic REG_AVG_COUNT  = 1'b0;
  localparam logic REG_SCALE_MODE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MV         = 2'd0,
    MODE_SHUNT_MA   = 2'd1,
    MODE_DIVIDER_MV = 2'd2,
    MODE_TEMP_CC    = 2'd3
  } scale_mode_t;

  // one finished burst handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [CODE_W-1:0] low;
    logic [CODE_W-1:0] high;
    scale_mode_t       mode;
  } job_t;

endpackage

@@ hw/rtl/abamm_front.sv @@
// ----------------------------------------------------------------------------
// abamm_front
// Accepts frames, drops burst-start frames and accumulates sum, min and max.
// ----------------------------------------------------------------------------
module abamm_front import abamm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [FRAME_W-1:0]  rx_frame,
  input  logic                first,
  input  logic [CNT_W-1:0]    avg_count,
  input  scale_mode_t         mode,
  output logic                job_valid,
  output job_t                job
);

  logic [CNT_W-1:0]  sample_count;
  logic [SUM_W-1:0]  code_sum;
  logic [CODE_W-1:0] low_code;
  logic [CODE_W-1:0] high_code;

  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  target;
  logic [CNT_W-1:0]  count_next;
  logic [SUM_W-1:0]  sum_next;
  logic [CODE_W-1:0] low_next;
  logic [CODE_W-1:0] high_next;
  logic              burst_end;

  // accumulate the current frame
  always_comb begin
    code       = rx_frame[CODE_W-1:0];
    target     = (avg_count == '0) ? CNT_W'(1) : avg_count;
    count_next = sample_count + CNT_W'(1);
    sum_next   = code_sum + SUM_W'(code);
    low_next   = (code < low_code) ? code : low_code;
    high_next  = (code > high_code) ? code : high_code;
    burst_end  = (count_next >= target);
    job_valid  = accept && !first && burst_end;
    job.sum    = sum_next;
    job.count  = count_next;
    job.low    = low_next;
    job.high   = high_next;
    job.mode   = mode;
  end

  // burst state, cleared by a first frame and after each completed burst
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      code_sum     <= '0;
      low_code     <= CODE_MAX;
      high_code    <= '0;
    end else if (accept) begin
      if (first || burst_end) begin
        sample_count <= '0;
        code_sum     <= '0;
        low_code     <= CODE_MAX;
        high_code    <= '0;
      end else begin
        sample_count <= count_next;
        code_sum     <= sum_next;
        low_code     <= low_next;
        high_code    <= high_next;
      end
    end
  end

endmodule

@@ hw/rtl/abamm_queue.sv @@
// ----------------------------------------------------------------------------
// abamm_queue
// Two-entry queue of finished bursts between front and back.
// ----------------------------------------------------------------------------
module abamm_queue import abamm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_job
);

  job_t       store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_job   = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 2'd1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/abamm_back.sv @@
// ----------------------------------------------------------------------------
// abamm_back
// Divides the burst sum bit-serially, scales the mean and holds the result.
// ----------------------------------------------------------------------------
module abamm_back import abamm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  job_t                       job,
  output logic                       job_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [CODE_W-1:0]          avg_code,
  output logic [CODE_W-1:0]          min_code,
  output logic [CODE_W-1:0]          max_code,
  output logic signed [SCALED_W-1:0] scaled_value
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SCALE
  } state_t;

  state_t            state;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic [CODE_W-1:0] low;
  logic [CODE_W-1:0] high;
  scale_mode_t       mode;
  logic [CODE_W-1:0] avg;
  logic [PROD_W-1:0] prod;
  logic              out_valid;

  logic [CNT_W:0]              rem_shift;
  logic                        fits;
  logic [CNT_W-1:0]            rem_next;
  logic [CODE_W-1:0]           mv;
  logic signed [SCALED_W-1:0]  mv_s;
  logic signed [SCALED_W-1:0]  temp_diff;
  logic signed [SCALED_W-1:0]  scaled;
  logic                        out_load;

  assign empty   = !out_valid;
  assign job_pop = (state == ST_IDLE) && job_valid;

  // one restoring division step
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    fits      = (rem_shift >= {1'b0, divisor});
    rem_next  = fits ? CNT_W'(rem_shift - {1'b0, divisor}) : rem_shift[CNT_W-1:0];
  end

  // millivolts and unit conversion
  always_comb begin
    mv        = prod[PROD_W-1:CODE_W];
    mv_s      = $signed({{(SCALED_W-CODE_W){1'b0}}, mv});
    temp_diff = mv_s - SCALED_W'(TEMP_OFFSET_MV);
    unique case (mode)
      MODE_MV:         scaled = mv_s;
      MODE_SHUNT_MA:   scaled = mv_s;
      MODE_DIVIDER_MV: scaled = mv_s <<< 1;
      MODE_TEMP_CC:    scaled = (temp_diff <<< 3) + (temp_diff <<< 1);
      default:         scaled = mv_s;
    endcase
    out_load = (state == ST_SCALE) && (!out_valid || pop);
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            quo     <= job.sum;
            rem     <= '0;
            divisor <= job.count;
            low     <= job.low;
            high    <= job.high;
            mode    <= job.mode;
            step    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo  <= {quo[SUM_W-2:0], fits};
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          avg   <= quo[CODE_W-1:0];
          prod  <= {{CODE_W{1'b0}}, quo[CODE_W-1:0]} * PROD_W'(MV_FULL);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // result slot: filled by the last step, freed by a transfer
      if (out_load) begin
        out_valid    <= 1'b1;
        avg_code     <= avg;
        min_code     <= low;
        max_code     <= high;
        scaled_value <= scaled;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/adc_burst_average_min_max_top.sv @@
// A burst-ending frame enters the burst queue; the back end dequeues it and
// runs 20 bit-serial division steps, a multiply and a scale on it.
// Throughput: one frame per cycle while the two-entry burst queue has room;
// the back end takes a new burst only once the last result is loaded.
// Reset: synchronous rst clears the burst, the queue and the result slot,
// and loads avg_count 10 and scale_mode 0. No clearing pass.
// ----------------------------------------------------------------------------
// adc_burst_average_min_max_top
// Burst averager with min/max tracking and unit scaling for a 12-bit ADC.
// ----------------------------------------------------------------------------
module adc_burst_average_min_max_top import abamm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // input queue side
  input  logic                       push,
  output logic                       full,
  input  logic [FRAME_W-1:0]         rx_frame,
  input  logic                       first,
  // result slot side
  output logic                       empty,
  input  logic                       pop,
  output logic [CODE_W-1:0]          avg_code,
  output logic [CODE_W-1:0]          min_code,
  output logic [CODE_W-1:0]          max_code,
  output logic signed [SCALED_W-1:0] scaled_value,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [CNT_W-1:0] avg_count;
  scale_mode_t      scale_mode;
  logic             accept;
  logic             fr_job_valid;
  job_t             fr_job;
  logic             q_valid;
  job_t             q_job;
  logic             q_pop;

  assign pready = 1'b1;
  assign accept = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count  <= CNT_W'(10);
      scale_mode <= MODE_MV;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_AVG_COUNT:  avg_count  <= pwdata[CNT_W-1:0];
        REG_SCALE_MODE: scale_mode <= scale_mode_t'(pwdata[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_AVG_COUNT:  prdata = {{(32-CNT_W){1'b0}}, avg_count};
      REG_SCALE_MODE: prdata = {{(32-MODE_W){1'b0}}, scale_mode};
      default:        prdata = '0;
    endcase
  end

  abamm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_frame  (rx_frame),
    .first     (first),
    .avg_count (avg_count),
    .mode      (scale_mode),
    .job_valid (fr_job_valid),
    .job       (fr_job)
  );

  abamm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fr_job_valid),
    .wr_job   (fr_job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  abamm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job          (q_job),
    .job_pop      (q_pop),
    .pop          (pop),
    .empty        (empty),
    .avg_code     (avg_code),
    .min_code     (min_code),
    .max_code     (max_code),
    .scaled_value (scaled_value)
  );

endmodule
